>>> sv/wraparound_repeat_alignment_assert.svh
// Assertion macros shared by the alignment RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef WRAPAROUND_REPEAT_ALIGNMENT_ASSERT_SVH
`define WRAPAROUND_REPEAT_ALIGNMENT_ASSERT_SVH

// Same-cycle implication.
`define WRA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WRA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/wra_pkg.sv
// Shared types and constants for the wraparound repeat alignment block.
// No dependencies.
package wra_pkg;

    localparam int MAX_UNIT_LEN_DEF = 32;
    localparam int MAX_READ_LEN_DEF = 512;
    localparam int MATRIX_DEPTH_DEF = 16929;

    localparam int SCORE_W = 16;
    localparam int CALC_W  = 18;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEL    = 2'd2;

    localparam logic [CFG_W-1:0] MATCH_RST    = 4'd2;
    localparam logic [CFG_W-1:0] MISMATCH_RST = 4'd1;
    localparam logic [CFG_W-1:0] INDEL_RST    = 4'd1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_OVER    = 2'd1,
        STATUS_TB_FAIL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BOUND,
        ST_CLEAR,
        ST_ROW_END,
        ST_CELL,
        ST_TB_ISSUE,
        ST_TB_CUR,
        ST_TB_DIAG,
        ST_TB_UP,
        ST_TB_LEFT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        TB_MATCH,
        TB_MISMATCH,
        TB_DELETE,
        TB_INSERT,
        TB_STOP,
        TB_FAIL
    } tb_move_t;

    typedef struct packed {
        tb_move_t           move;
        logic [SCORE_W-1:0] cur_next;
    } tb_dec_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] symbol;
        logic       is_last;
    } req_t;

    typedef struct packed {
        logic [9:0]  match_count;
        logic [9:0]  mismatch_count;
        logic [9:0]  insertion_count;
        logic [14:0] deletion_count;
        logic [4:0]  start_phase;
        logic [1:0]  status;
    } rsp_t;

endpackage

>>> sv/wra_score_unit.sv
// Shared score arithmetic: cell recurrence for the fill and the step choice
// for the traceback. Depends on wra_pkg.
module wra_score_unit (
    input  logic                          same,
    input  logic                          col_gt1,
    input  logic [wra_pkg::SCORE_W-1:0]   diag,
    input  logic [wra_pkg::SCORE_W-1:0]   up,
    input  logic [wra_pkg::SCORE_W-1:0]   left,
    input  logic [wra_pkg::SCORE_W-1:0]   cur,
    input  logic [wra_pkg::CFG_W-1:0]     gain_amt,
    input  logic [wra_pkg::CFG_W-1:0]     sub_cost,
    input  logic [wra_pkg::CFG_W-1:0]     gap_cost,
    output logic [wra_pkg::SCORE_W-1:0]   cell_score,
    output wra_pkg::tb_dec_t              tb_dec
);

    logic signed [wra_pkg::CALC_W-1:0] diag_s;
    logic signed [wra_pkg::CALC_W-1:0] cur_s;
    logic signed [wra_pkg::CALC_W-1:0] mg_s;
    logic signed [wra_pkg::CALC_W-1:0] mp_s;
    logic signed [wra_pkg::CALC_W-1:0] ip_s;
    logic signed [wra_pkg::CALC_W-1:0] gain_s;
    logic signed [wra_pkg::CALC_W-1:0] sub_s;
    logic signed [wra_pkg::CALC_W-1:0] up_s;
    logic signed [wra_pkg::CALC_W-1:0] left_s;
    logic signed [wra_pkg::CALC_W-1:0] best_s;

    assign diag_s = signed'({2'b00, diag});
    assign cur_s  = signed'({2'b00, cur});
    assign mg_s   = signed'(wra_pkg::CALC_W'(gain_amt));
    assign mp_s   = signed'(wra_pkg::CALC_W'(sub_cost));
    assign ip_s   = signed'(wra_pkg::CALC_W'(gap_cost));
    assign gain_s = diag_s + mg_s;
    assign sub_s  = diag_s - mp_s;
    assign up_s   = signed'({2'b00, up}) - ip_s;
    assign left_s = signed'({2'b00, left}) - ip_s;

    always_comb
    begin
        best_s = '0;
        if (sub_s > best_s)
        begin
            best_s = sub_s;
        end
        if (up_s > best_s)
        begin
            best_s = up_s;
        end
        if (col_gt1 && left_s > best_s)
        begin
            best_s = left_s;
        end
        if (same)
        begin
            best_s = gain_s;
        end
        cell_score = best_s[wra_pkg::SCORE_W-1:0];
    end

    // Step priority: match, mismatch, deletion, insertion.
    always_comb
    begin
        tb_dec.cur_next = cur;
        if (same && cur_s == gain_s)
        begin
            tb_dec.move     = wra_pkg::TB_MATCH;
            tb_dec.cur_next = wra_pkg::SCORE_W'(cur_s - mg_s);
        end
        else if (!same && cur_s == sub_s)
        begin
            tb_dec.move     = wra_pkg::TB_MISMATCH;
            tb_dec.cur_next = wra_pkg::SCORE_W'(cur_s + mp_s);
        end
        else if (col_gt1 && cur_s == left_s)
        begin
            tb_dec.move     = wra_pkg::TB_DELETE;
            tb_dec.cur_next = wra_pkg::SCORE_W'(cur_s + ip_s);
        end
        else if (cur_s == up_s)
        begin
            tb_dec.move     = wra_pkg::TB_INSERT;
            tb_dec.cur_next = wra_pkg::SCORE_W'(cur_s + ip_s);
        end
        else if (cur == '0)
        begin
            tb_dec.move = wra_pkg::TB_STOP;
        end
        else
        begin
            tb_dec.move = wra_pkg::TB_FAIL;
        end
    end

endmodule

>>> sv/wraparound_repeat_alignment.sv
// Wraparound repeat alignment: usage
// req channel (valid/ready) carries one symbol per word: req_type 0 appends
// a unit symbol, 1 appends a read symbol; is_last on a read symbol starts
// the alignment. rsp channel (valid/ready) returns one word per job: counts,
// start phase and status. cfg_we/cfg_index/cfg_data write the three score
// registers (match gain, mismatch penalty, indel penalty); the user must
// write them only while idle, which the block does not enforce. Symbols
// load one word per cycle while idle. A job clears row zero of the score
// memory, fills one row per read symbol, then traces back from the best
// cell; the fill walks one cell a cycle, and each traceback step costs
// four score memory reads. req_ready is low for the whole job.
// A finished word sits in the rsp register; a stalled receiver holds the
// block in its final state but loading of the next job's symbols resumes
// only after the word is taken into that register.
// Reset clears lengths, overflow flags, the response register and sets the
// score registers to 2/1/1. Stores need no clearing: row zero of the score
// memory is rewritten at the start of every job.
// Depends on wra_pkg, wra_score_unit and the assertion header.
`include "wraparound_repeat_alignment_assert.svh"

module wraparound_repeat_alignment #(
    parameter int MAX_UNIT_LEN = wra_pkg::MAX_UNIT_LEN_DEF,
    parameter int MAX_READ_LEN = wra_pkg::MAX_READ_LEN_DEF,
    parameter int MATRIX_DEPTH = wra_pkg::MATRIX_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  wra_pkg::req_t                   req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output wra_pkg::rsp_t                   rsp,
    input  logic                            cfg_we,
    input  logic [wra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wra_pkg::CFG_W-1:0]       cfg_data
);

    localparam int UL_W   = $clog2(MAX_UNIT_LEN + 1);
    localparam int RL_W   = $clog2(MAX_READ_LEN + 1);
    localparam int UA_W   = (MAX_UNIT_LEN > 1) ? $clog2(MAX_UNIT_LEN) : 1;
    localparam int RA_W   = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
    localparam int ADDR_W = $clog2(MATRIX_DEPTH);
    localparam int PROD_W = UL_W + 1 + RL_W;
    localparam int CMP_W  = (PROD_W + 1 > ADDR_W + 1) ? PROD_W + 1 : ADDR_W + 1;
    localparam int SW     = wra_pkg::SCORE_W;

    // storage
    logic [7:0]    unit_mem [MAX_UNIT_LEN];
    logic [7:0]    read_mem [MAX_READ_LEN];
    logic [SW-1:0] score_mem [MATRIX_DEPTH];

    wra_pkg::state_t state_reg, state_next;

    logic [UL_W-1:0]   ul_reg;
    logic [RL_W-1:0]   rl_reg;
    logic              uover_reg;
    logic              rover_reg;
    logic [wra_pkg::CFG_W-1:0] mg_reg, mp_reg, ip_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [ADDR_W-1:0] w_reg;
    logic [ADDR_W-1:0] base_cur_reg;
    logic [ADDR_W-1:0] base_prev_reg;
    logic [RL_W-1:0]   i_reg;
    logic [UL_W-1:0]   j_reg;
    logic [SW-1:0]     diag_reg;
    logic [SW-1:0]     left_reg;
    logic [SW-1:0]     up_reg;
    logic [SW-1:0]     cur_reg;
    logic [SW-1:0]     best_reg;
    logic [RL_W-1:0]   bi_reg;
    logic [UL_W-1:0]   bj_reg;
    logic [ADDR_W-1:0] bbase_reg;
    logic [9:0]        mat_reg, mis_reg, ins_reg;
    logic [14:0]       del_reg;
    wra_pkg::status_t  status_reg;

    logic              rsp_valid_reg;
    wra_pkg::rsp_t     rsp_reg;
    wra_pkg::rsp_t     rsp_fill;

    // memory ports
    logic              sm_we;
    logic [ADDR_W-1:0] sm_waddr;
    logic [SW-1:0]     sm_wdata;
    logic [ADDR_W-1:0] sm_raddr;
    logic [SW-1:0]     sm_rdata_reg;
    logic [UA_W-1:0]   um_raddr;
    logic [7:0]        um_rdata_reg;
    logic [RA_W-1:0]   rm_raddr;
    logic [7:0]        rm_rdata_reg;

    logic              req_fire;
    logic              bound_ok;
    logic              rsp_free;
    logic              same;
    logic              col_gt1;
    logic [SW-1:0]     su_up;
    logic [SW-1:0]     su_left;
    logic [SW-1:0]     cell_score;
    wra_pkg::tb_dec_t  tb_dec;
    logic [UL_W-1:0]   j_dec;
    logic [UL_W-1:0]   j_wrap;
    logic [UL_W-1:0]   j_init;
    logic [4:0]        phase;

    assign req_ready = (state_reg == wra_pkg::ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign bound_ok = (CMP_W'(prod_reg) + CMP_W'(ul_reg)) < CMP_W'(MATRIX_DEPTH);

    assign same    = (rm_rdata_reg == um_rdata_reg);
    assign col_gt1 = (j_reg > UL_W'(1));
    assign su_up   = (state_reg == wra_pkg::ST_CELL) ? sm_rdata_reg : up_reg;
    assign su_left = (state_reg == wra_pkg::ST_CELL) ? left_reg : sm_rdata_reg;

    assign j_dec  = j_reg - UL_W'(1);
    assign j_wrap = (j_dec == '0) ? ul_reg : j_dec;
    assign j_init = (bj_reg == '0) ? ul_reg : bj_reg;
    assign phase  = (j_reg == ul_reg) ? 5'd0 : 5'(j_reg);

    wra_score_unit u_score (
        .same       (same),
        .col_gt1    (col_gt1),
        .diag       (diag_reg),
        .up         (su_up),
        .left       (su_left),
        .cur        (cur_reg),
        .gain_amt   (mg_reg),
        .sub_cost   (mp_reg),
        .gap_cost   (ip_reg),
        .cell_score (cell_score),
        .tb_dec     (tb_dec)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wra_pkg::ST_IDLE:
                if (req_fire && req.req_type && req.is_last)
                begin
                    state_next = wra_pkg::ST_CHECK;
                end
            wra_pkg::ST_CHECK:
                state_next = (uover_reg || rover_reg || ul_reg == '0) ?
                             wra_pkg::ST_DONE : wra_pkg::ST_BOUND;
            wra_pkg::ST_BOUND:
                state_next = bound_ok ? wra_pkg::ST_CLEAR : wra_pkg::ST_DONE;
            wra_pkg::ST_CLEAR:
                if (j_reg == ul_reg)
                begin
                    state_next = wra_pkg::ST_ROW_END;
                end
            wra_pkg::ST_ROW_END:
                state_next = (i_reg == rl_reg) ? wra_pkg::ST_TB_ISSUE : wra_pkg::ST_CELL;
            wra_pkg::ST_CELL:
                if (j_reg == ul_reg)
                begin
                    state_next = wra_pkg::ST_ROW_END;
                end
            wra_pkg::ST_TB_ISSUE:
                state_next = (i_reg == '0) ? wra_pkg::ST_DONE : wra_pkg::ST_TB_CUR;
            wra_pkg::ST_TB_CUR:
                state_next = (sm_rdata_reg == '0) ? wra_pkg::ST_DONE : wra_pkg::ST_TB_DIAG;
            wra_pkg::ST_TB_DIAG:
                state_next = wra_pkg::ST_TB_UP;
            wra_pkg::ST_TB_UP:
                state_next = wra_pkg::ST_TB_LEFT;
            wra_pkg::ST_TB_LEFT:
                if (tb_dec.move == wra_pkg::TB_STOP || tb_dec.move == wra_pkg::TB_FAIL)
                begin
                    state_next = wra_pkg::ST_DONE;
                end
                else
                begin
                    state_next = wra_pkg::ST_TB_ISSUE;
                end
            wra_pkg::ST_DONE:
                if (rsp_free)
                begin
                    state_next = wra_pkg::ST_IDLE;
                end
            default:
                state_next = wra_pkg::ST_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        sm_we    = 1'b0;
        sm_waddr = base_cur_reg + ADDR_W'(j_reg);
        sm_wdata = cell_score;
        sm_raddr = base_cur_reg + ADDR_W'(j_reg);
        um_raddr = j_dec[UA_W-1:0];
        rm_raddr = RA_W'(i_reg - RL_W'(1));
        unique case (state_reg)
            wra_pkg::ST_CLEAR:
            begin
                sm_we    = 1'b1;
                sm_waddr = ADDR_W'(j_reg);
                sm_wdata = '0;
            end
            wra_pkg::ST_ROW_END:
            begin
                // column 0 takes the row's last column
                sm_we    = 1'b1;
                sm_waddr = base_cur_reg;
                sm_wdata = left_reg;
                sm_raddr = base_cur_reg + ADDR_W'(1);
                um_raddr = '0;
                rm_raddr = RA_W'(i_reg);
            end
            wra_pkg::ST_CELL:
            begin
                sm_we    = 1'b1;
                sm_raddr = base_prev_reg + ADDR_W'(j_reg) + ADDR_W'(1);
                um_raddr = j_reg[UA_W-1:0];
            end
            wra_pkg::ST_TB_CUR:
                sm_raddr = base_cur_reg - w_reg + ADDR_W'(j_reg) - ADDR_W'(1);
            wra_pkg::ST_TB_DIAG:
                sm_raddr = base_cur_reg - w_reg + ADDR_W'(j_reg);
            wra_pkg::ST_TB_UP:
                sm_raddr = base_cur_reg + ADDR_W'(j_reg) - ADDR_W'(1);
            default:
            begin
            end
        endcase
    end

    // result word assembled from the job registers
    always_comb
    begin
        rsp_fill        = '0;
        rsp_fill.status = status_reg;
        if (status_reg == wra_pkg::STATUS_OK)
        begin
            rsp_fill.match_count     = mat_reg;
            rsp_fill.mismatch_count  = mis_reg;
            rsp_fill.insertion_count = ins_reg;
            rsp_fill.deletion_count  = del_reg;
            rsp_fill.start_phase     = phase;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            score_mem[sm_waddr] <= sm_wdata;
        end
        sm_rdata_reg <= score_mem[sm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && !req.req_type && ul_reg < UL_W'(MAX_UNIT_LEN))
        begin
            unit_mem[ul_reg[UA_W-1:0]] <= req.symbol;
        end
        um_rdata_reg <= unit_mem[um_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && req.req_type && rl_reg < RL_W'(MAX_READ_LEN))
        begin
            read_mem[rl_reg[RA_W-1:0]] <= req.symbol;
        end
        rm_rdata_reg <= read_mem[rm_raddr];
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mg_reg <= wra_pkg::MATCH_RST;
            mp_reg <= wra_pkg::MISMATCH_RST;
            ip_reg <= wra_pkg::INDEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wra_pkg::CFG_MATCH:    mg_reg <= cfg_data;
                wra_pkg::CFG_MISMATCH: mp_reg <= cfg_data;
                wra_pkg::CFG_INDEL:    ip_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wra_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ul_reg        <= '0;
            rl_reg        <= '0;
            uover_reg     <= 1'b0;
            rover_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            prod_reg      <= '0;
            w_reg         <= '0;
            base_cur_reg  <= '0;
            base_prev_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            diag_reg      <= '0;
            left_reg      <= '0;
            up_reg        <= '0;
            cur_reg       <= '0;
            best_reg      <= '0;
            bi_reg        <= '0;
            bj_reg        <= '0;
            bbase_reg     <= '0;
            mat_reg       <= '0;
            mis_reg       <= '0;
            ins_reg       <= '0;
            del_reg       <= '0;
            status_reg    <= wra_pkg::STATUS_OK;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && state_reg != wra_pkg::ST_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                wra_pkg::ST_IDLE:
                    if (req_fire)
                    begin
                        if (!req.req_type)
                        begin
                            if (ul_reg < UL_W'(MAX_UNIT_LEN))
                            begin
                                ul_reg <= ul_reg + UL_W'(1);
                            end
                            else
                            begin
                                uover_reg <= 1'b1;
                            end
                        end
                        else if (rl_reg < RL_W'(MAX_READ_LEN))
                        begin
                            rl_reg <= rl_reg + RL_W'(1);
                        end
                        else
                        begin
                            rover_reg <= 1'b1;
                        end
                    end
                wra_pkg::ST_CHECK:
                begin
                    prod_reg   <= PROD_W'((UL_W + 1)'(ul_reg) + (UL_W + 1)'(1))
                                * PROD_W'(rl_reg);
                    mat_reg    <= '0;
                    mis_reg    <= '0;
                    ins_reg    <= '0;
                    del_reg    <= '0;
                    j_reg      <= '0;
                    status_reg <= (uover_reg || rover_reg) ? wra_pkg::STATUS_OVER
                                                           : wra_pkg::STATUS_OK;
                end
                wra_pkg::ST_BOUND:
                begin
                    if (!bound_ok)
                    begin
                        status_reg <= wra_pkg::STATUS_OVER;
                    end
                    w_reg        <= ADDR_W'(ul_reg) + ADDR_W'(1);
                    base_cur_reg <= '0;
                    i_reg        <= '0;
                    j_reg        <= '0;
                    left_reg     <= '0;
                    best_reg     <= '0;
                    bi_reg       <= '0;
                    bj_reg       <= '0;
                    bbase_reg    <= '0;
                end
                wra_pkg::ST_CLEAR:
                    j_reg <= j_reg + UL_W'(1);
                wra_pkg::ST_ROW_END:
                begin
                    diag_reg <= left_reg;
                    if (i_reg == rl_reg)
                    begin
                        // traceback starts at the first best cell
                        i_reg        <= bi_reg;
                        j_reg        <= j_init;
                        base_cur_reg <= bbase_reg;
                        cur_reg      <= best_reg;
                    end
                    else
                    begin
                        base_prev_reg <= base_cur_reg;
                        base_cur_reg  <= base_cur_reg + w_reg;
                        i_reg         <= i_reg + RL_W'(1);
                        j_reg         <= UL_W'(1);
                    end
                end
                wra_pkg::ST_CELL:
                begin
                    left_reg <= cell_score;
                    diag_reg <= sm_rdata_reg;
                    j_reg    <= j_reg + UL_W'(1);
                    if (cell_score > best_reg)
                    begin
                        best_reg  <= cell_score;
                        bi_reg    <= i_reg;
                        bj_reg    <= j_reg;
                        bbase_reg <= base_cur_reg;
                    end
                end
                wra_pkg::ST_TB_DIAG:
                    diag_reg <= sm_rdata_reg;
                wra_pkg::ST_TB_UP:
                    up_reg <= sm_rdata_reg;
                wra_pkg::ST_TB_LEFT:
                begin
                    cur_reg <= tb_dec.cur_next;
                    case (tb_dec.move)
                        wra_pkg::TB_MATCH:
                        begin
                            mat_reg      <= mat_reg + 10'd1;
                            i_reg        <= i_reg - RL_W'(1);
                            j_reg        <= j_wrap;
                            base_cur_reg <= base_cur_reg - w_reg;
                        end
                        wra_pkg::TB_MISMATCH:
                        begin
                            mis_reg      <= mis_reg + 10'd1;
                            i_reg        <= i_reg - RL_W'(1);
                            j_reg        <= j_wrap;
                            base_cur_reg <= base_cur_reg - w_reg;
                        end
                        wra_pkg::TB_DELETE:
                        begin
                            del_reg <= del_reg + 15'd1;
                            j_reg   <= j_dec;
                        end
                        wra_pkg::TB_INSERT:
                        begin
                            ins_reg      <= ins_reg + 10'd1;
                            i_reg        <= i_reg - RL_W'(1);
                            base_cur_reg <= base_cur_reg - w_reg;
                        end
                        wra_pkg::TB_FAIL:
                            status_reg <= wra_pkg::STATUS_TB_FAIL;
                        default:
                        begin
                        end
                    endcase
                end
                wra_pkg::ST_DONE:
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg       <= rsp_fill;
                        ul_reg        <= '0;
                        rl_reg        <= '0;
                        uover_reg     <= 1'b0;
                        rover_reg     <= 1'b0;
                    end
                default:
                begin
                end
            endcase
        end
    end

    `WRA_ASSERT_NOW(a_cell_col_range, state_reg == wra_pkg::ST_CELL,
        j_reg != '0 && j_reg <= ul_reg, "fill column out of range")
    `WRA_ASSERT_NOW(a_len_cap, 1'b1,
        ul_reg <= UL_W'(MAX_UNIT_LEN) && rl_reg <= RL_W'(MAX_READ_LEN),
        "stored length above capacity")
    `WRA_ASSERT_NEXT(a_rsp_from_done,
        state_reg != wra_pkg::ST_DONE && !rsp_valid_reg, !rsp_valid_reg,
        "response raised outside the final state")
    `WRA_ASSERT_NOW(a_tb_col_range,
        state_reg == wra_pkg::ST_TB_LEFT,
        j_reg != '0 && j_reg <= ul_reg && i_reg != '0,
        "traceback position out of range")

endmodule
